>>> sv/pbfs_pkg.sv
`timescale 1ns / 1ps
// Package for the packed bit field store: item types, mode codes and constants.
// Depends on nothing; the top level imports it.
package pbfs_pkg;

    localparam int DEF_STORE_WORDS = 1024;
    localparam int DEF_WORD_BITS   = 64;

    // Bit positions and the fill level are 17 bits wide.
    localparam int POS_W        = 17;
    localparam int FILL_MAX_INT = 131071;
    // Wide enough for the capacity of the largest store (65536 words of 64 bits).
    localparam int CAP_W        = 24;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_GET    = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] bit_index;
        logic [63:0] field_value;
        logic [6:0]  field_width;
    } t_in_item;

    typedef struct packed {
        logic [63:0]      read_data;
        logic [POS_W-1:0] fill_level;
        logic             range_error;
    } t_out_item;

    // Mask of the n lowest bits, all ones for n of 64 or more.
    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

endpackage

>>> sv/packed_bit_field_store.sv
`timescale 1ns / 1ps
// Packed bit field store: a banked word memory holding one MSB-first bit string.
// Depends on pbfs_pkg for the item types, mode codes and the mask function.
//
// Usage. Items enter on the input channel (i_in_valid, o_in_stall, i_in_data) and
// one result leaves per item on the output channel (o_out_valid, i_out_stall,
// o_out_data). A transfer happens at a rising edge where valid is high and stall
// is low. An item appends a field at the fill level, sets a field at bit_index,
// or gets a field from bit_index, right aligned. A field of up to WORD_BITS bits
// may straddle two words; even and odd words sit in separate banks, so both
// words are read together and written back together.
// An item passes through four steps, one per state. The first registers the
// decoded item and its range checks, the second finds the word index by a
// reciprocal multiply, the third reads both banks, and the fourth merges,
// writes back and loads the output register. A new transfer is taken only once
// the last step is done, so no new item enters before the last one is through.
// Since the block holds one item at a time, a read never overlaps the
// write-back of the same word.
// When the receiver stalls, the result waits in the output register and the
// next item stops in its last step until the register frees; the memory read
// data hold meanwhile. Reset clears the fill level and the control state only:
// a get may only read below the fill level, and every such bit was written by
// an append, so the memory words need no clearing pass.
module packed_bit_field_store
    import pbfs_pkg::*;
#(
    parameter int STORE_WORDS = DEF_STORE_WORDS,
    parameter int WORD_BITS   = DEF_WORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int HALF_WORDS  = (STORE_WORDS + 1) / 2;
    localparam int BAW         = (HALF_WORDS > 1) ? $clog2(HALF_WORDS) : 1;
    localparam int BANK_DEPTH  = 2 ** BAW;
    localparam logic [CAP_W-1:0] CAP = CAP_W'(STORE_WORDS * WORD_BITS);
    localparam logic [CAP_W-1:0] FILL_LIMIT = CAP_W'(FILL_MAX_INT);
    // The word index is pos * RECIP >> RECIP_SHIFT, exact for all 17-bit positions.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = POS_W + RECIP_W;
    localparam int Q_W         = $clog2(FILL_MAX_INT / WORD_BITS + 1);
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int WIN_W       = 2 * WORD_BITS;
    localparam int SH_W        = $clog2(WIN_W);
    localparam int SHX_W       = SH_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_WR   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_fill, n_fill;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out;

    // Decoded item.
    logic [POS_W-1:0] r_pos;
    logic [6:0]       r_n;
    logic [63:0]      r_val;
    logic             r_we;
    logic             r_rd_ok;
    logic             r_err;

    // Address step results.
    logic [Q_W-1:0]   r_q;
    logic [SH_W-1:0]  r_sh;
    logic             r_strad;
    logic             r_wodd;
    logic [BAW-1:0]   r_ev_addr;
    logic [BAW-1:0]   r_od_addr;

    // Banks and their registered read data.
    logic [WORD_BITS-1:0] mem_ev [BANK_DEPTH];
    logic [WORD_BITS-1:0] mem_od [BANK_DEPTH];
    logic [WORD_BITS-1:0] r_ev_rd;
    logic [WORD_BITS-1:0] r_od_rd;

    logic             w_accept;
    logic             w_advance;
    logic [6:0]       w_n;
    logic             w_wbad;
    logic [CAP_W-1:0] w_end_app;
    logic [CAP_W-1:0] w_end_idx;
    logic             w_err;
    logic             w_is_app;
    logic             w_is_set;
    logic             w_is_get;
    logic [PROD_W-1:0] w_prod;
    logic [AW-1:0]    w_word;
    logic [BAW-1:0]   w_half;
    logic [BAW-1:0]   w_ev_addr;
    logic [POS_W-1:0] w_off_full;
    logic [OFF_W-1:0] w_off;
    logic [SHX_W-1:0] w_shx;
    logic [SH_W-1:0]  w_sh;
    logic [WIN_W-1:0] w_old;
    logic [WIN_W-1:0] w_mask;
    logic [WIN_W-1:0] w_data;
    logic [WIN_W-1:0] w_new;
    logic [WORD_BITS-1:0] w_wd_ev;
    logic [WORD_BITS-1:0] w_wd_od;
    logic             w_we_ev;
    logic             w_we_od;
    logic [63:0]      w_rd_data;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Range checks at acceptance, against the fill level before this item.
    always_comb begin
        w_n       = i_in_data.field_width;
        w_wbad    = (w_n == 7'd0) || (w_n > 7'(WORD_BITS));
        w_end_app = CAP_W'(r_fill) + CAP_W'(w_n);
        w_end_idx = CAP_W'(i_in_data.bit_index) + CAP_W'(w_n);
        w_is_app  = 1'b0;
        w_is_set  = 1'b0;
        w_is_get  = 1'b0;
        w_err     = 1'b0;
        case (i_in_data.mode)
            MODE_APPEND: begin
                w_is_app = 1'b1;
                w_err    = w_wbad || (w_end_app > CAP) || (w_end_app > FILL_LIMIT);
            end
            MODE_SET: begin
                w_is_set = 1'b1;
                w_err    = w_wbad || (w_end_idx > CAP);
            end
            MODE_GET: begin
                w_is_get = 1'b1;
                w_err    = w_wbad || (w_end_idx > CAP_W'(r_fill)) || (w_end_idx > CAP);
            end
            default: begin
                w_err = 1'b0;
            end
        endcase
    end

    // Word index and bit offset of the field's first bit.
    assign w_prod     = PROD_W'(r_pos) * PROD_W'(RECIP);
    assign w_word     = AW'(r_q);
    assign w_half     = BAW'(w_word >> 1);
    assign w_ev_addr  = w_word[0] ? (w_half + BAW'(1)) : w_half;
    assign w_off_full = r_pos - POS_W'(POS_W'(r_q) * POS_W'(WORD_BITS));
    assign w_off      = OFF_W'(w_off_full);
    assign w_shx      = SHX_W'(WIN_W) - SHX_W'(w_off) - SHX_W'(r_n);
    assign w_sh       = SH_W'(w_shx);

    // Two-word window with the first word on top; the field ends r_sh bits above
    // the window's bottom.
    always_comb begin
        w_old     = r_wodd ? {r_od_rd, r_ev_rd} : {r_ev_rd, r_od_rd};
        w_mask    = WIN_W'(low_mask(r_n)) << r_sh;
        w_data    = WIN_W'(r_val) << r_sh;
        w_new     = (w_old & ~w_mask) | (w_data & w_mask);
        w_wd_ev   = r_wodd ? w_new[WORD_BITS-1:0] : w_new[WIN_W-1:WORD_BITS];
        w_wd_od   = r_wodd ? w_new[WIN_W-1:WORD_BITS] : w_new[WORD_BITS-1:0];
        w_we_ev   = (r_state == S_WR) && w_advance && r_we && (r_wodd ? r_strad : 1'b1);
        w_we_od   = (r_state == S_WR) && w_advance && r_we && (r_wodd ? 1'b1 : r_strad);
        w_rd_data = r_rd_ok ? (64'(w_old >> r_sh) & low_mask(r_n)) : 64'd0;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                    if (w_is_app && !w_err) begin
                        n_fill = POS_W'(w_end_app);
                    end
                end
            end
            S_DIV: begin
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (w_advance) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos   <= w_is_app ? r_fill : POS_W'(i_in_data.bit_index);
            r_n     <= w_n;
            r_val   <= i_in_data.field_value & low_mask(w_n);
            r_we    <= (w_is_app || w_is_set) && !w_err;
            r_rd_ok <= w_is_get && !w_err;
            r_err   <= w_err;
        end
        if (r_state == S_DIV) begin
            r_q <= Q_W'(w_prod >> RECIP_SHIFT);
        end
        if (r_state == S_RD) begin
            r_sh      <= w_sh;
            r_strad   <= (w_sh < SH_W'(WORD_BITS));
            r_wodd    <= w_word[0];
            r_ev_addr <= w_ev_addr;
            r_od_addr <= w_half;
        end
        if ((r_state == S_WR) && w_advance) begin
            r_out.read_data   <= w_rd_data;
            r_out.fill_level  <= r_fill;
            r_out.range_error <= r_err;
        end
    end

    // Even bank: read in the address step, written back in the last step.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_ev_rd <= mem_ev[w_ev_addr];
        end
        if (w_we_ev) begin
            mem_ev[r_ev_addr] <= w_wd_ev;
        end
    end

    // Odd bank.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_od_rd <= mem_od[w_half];
        end
        if (w_we_od) begin
            mem_od[r_od_addr] <= w_wd_od;
        end
    end

    // The fill level only grows between resets.
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill >= $past(r_fill)))
        else $error("fill level decreased");

    // A result appears only out of the write-back step.
    a_result_from_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_WR))
        else $error("result loaded outside write-back");

    // A refused item never returns data.
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |-> (o_out_data.read_data == 64'd0))
        else $error("refused item returned data");

    // The reported fill level stays within the store's capacity.
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAP_W'(o_out_data.fill_level) <= CAP))
        else $error("fill level beyond capacity");

    // Both banks are never written back while an item is still being accepted.
    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !(w_we_ev || w_we_od))
        else $error("memory write overlaps item transfer");

endmodule
